// ----- rtl/core/qpht_pkg.sv -----
// Shared types and constants for the quadratic-probe hash table.
// Used by every module under rtl/core; depends on nothing else.
package qpht_pkg;

  // Default table capacity and field widths
  localparam int unsigned DEF_MAX_SLOTS = 1024;
  localparam int unsigned KEY_W         = 31;
  localparam int unsigned TSIZE_W       = 11;
  localparam int unsigned SLOT_W        = 10;
  localparam int unsigned COLL_W        = 11;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned KBIT_W        = $clog2(KEY_W);

  localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd1021;

  // Command codes
  localparam logic CMD_FIND   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // One table entry: occupancy flag and stored key
  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
  } entry_t;

  // One finished result handed to the output register
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COLL_W-1:0]   collisions;
  } result_t;

  // Modular adder operation
  typedef enum logic {
    MOD_ADD,
    MOD_SUB
  } mod_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RD,
    S_CMP,
    S_SQ,
    S_POS
  } seq_state_t;

endpackage

// ----- rtl/core/qpht_modunit.sv -----
// Shared modular add/subtract unit: (a + b + cin) or (a - b) wrapped into 0 .. size-1.
// Depends on qpht_pkg. Operands must satisfy a < size and b <= size.
module qpht_modunit
  import qpht_pkg::*;
#(
  parameter int unsigned SIZE_W = 11
) (
  input  mod_op_t           op,
  input  logic [SIZE_W-1:0] a,
  input  logic [SIZE_W-1:0] b,
  input  logic              cin,
  input  logic [SIZE_W-1:0] size,
  output logic [SIZE_W-1:0] res
);

  logic [SIZE_W:0] sum;
  logic [SIZE_W:0] diff;

  // Form the raw sum and difference one bit wider than the operands
  assign sum  = {1'b0, a} + {1'b0, b} + {{SIZE_W{1'b0}}, cin};
  assign diff = {1'b0, a} - {1'b0, b};

  // Fold back into range with a single correction
  always_comb begin
    unique case (op)
      MOD_ADD: begin
        if (sum >= {1'b0, size}) begin
          res = SIZE_W'(sum - {1'b0, size});
        end else begin
          res = sum[SIZE_W-1:0];
        end
      end
      MOD_SUB: begin
        if (diff[SIZE_W]) begin
          res = SIZE_W'(diff + {1'b0, size});
        end else begin
          res = diff[SIZE_W-1:0];
        end
      end
      default: begin
        res = sum[SIZE_W-1:0];
      end
    endcase
  end

endmodule

// ----- rtl/core/qpht_mem.sv -----
// Single-port slot memory holding occupancy flag and key per slot.
// Depends on qpht_pkg; read data is registered and loads only on a read enable.
module qpht_mem
  import qpht_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [$clog2(MAX_SLOTS)-1:0] addr,
  input  entry_t                       wdata,
  output entry_t                       rdata
);

  entry_t mem [MAX_SLOTS];
  entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port; hold the last read otherwise
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/qpht_seq.sv -----
// Probe sequencer: key reduction, alternating quadratic probing, insert and clear sweep.
// Depends on qpht_pkg and qpht_modunit; drives the slot memory port.
module qpht_seq
  import qpht_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input beat
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [KEY_W-1:0]                     in_key,
  // Effective table size, already clamped
  input  logic [$clog2(MAX_SLOTS+1)-1:0]       size_i,
  // Finished result towards the output register
  output logic                                 done_valid,
  input  logic                                 done_ready,
  output result_t                              done_res,
  // Slot memory port
  output logic                                 mem_we,
  output logic                                 mem_re,
  output logic [$clog2(MAX_SLOTS)-1:0]         mem_addr,
  output entry_t                               mem_wdata,
  input  entry_t                               mem_rdata
);

  localparam int unsigned SIZE_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_SLOTS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_SLOTS - 1);
  localparam logic [KBIT_W-1:0] TOP_KBIT  = KBIT_W'(KEY_W - 1);

  seq_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [KBIT_W-1:0]   cnt_r, cnt_nxt;
  logic                cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [SIZE_W-1:0]   home_r, home_nxt;
  logic [SIZE_W-1:0]   pos_r, pos_nxt;
  logic [SIZE_W-1:0]   sq_r, sq_nxt;
  logic [SIZE_W-1:0]   d_r, d_nxt;
  logic [SIZE_W-1:0]   coll_r, coll_nxt;

  mod_op_t             mu_op;
  logic [SIZE_W-1:0]   mu_a, mu_b, mu_res;
  logic                mu_cin;

  logic                hit;
  logic [SIZE_W-1:0]   coll_inc;
  logic                full;
  logic                finish;

  // Probe outcome, valid in S_CMP
  assign hit      = !mem_rdata.occ || (mem_rdata.key == key_r);
  assign coll_inc = coll_r + SIZE_W'(1);
  assign full     = !hit && (coll_inc == size_r);
  assign finish   = hit || full;

  // Shared modular unit
  qpht_modunit #(
    .SIZE_W (SIZE_W)
  ) u_modunit (
    .op   (mu_op),
    .a    (mu_a),
    .b    (mu_b),
    .cin  (mu_cin),
    .size (size_r),
    .res  (mu_res)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (finish) begin
          if (done_ready) begin
            state_nxt = S_IDLE;
          end
        end else if (coll_inc[0]) begin
          state_nxt = S_SQ;
        end else begin
          state_nxt = S_POS;
        end
      end
      S_SQ: begin
        state_nxt = S_POS;
      end
      S_POS: begin
        state_nxt = S_RD;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Outputs: handshake, memory port, modular unit operands
  always_comb begin
    in_ready   = 1'b0;
    done_valid = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = pos_r[ADDR_W-1:0];
    mem_wdata  = '{occ: 1'b1, key: key_r};
    mu_op      = MOD_ADD;
    mu_a       = home_r;
    mu_b       = sq_r;
    mu_cin     = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '{occ: 1'b0, key: '0};
      end
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_DIV: begin
        mu_a   = pos_r;
        mu_b   = pos_r;
        mu_cin = key_r[cnt_r];
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_CMP: begin
        done_valid = finish;
        mem_we     = hit && !mem_rdata.occ && (cmd_r == CMD_INSERT);
      end
      S_SQ: begin
        mu_a = sq_r;
        mu_b = d_r;
      end
      S_POS: begin
        mu_op = coll_r[0] ? MOD_ADD : MOD_SUB;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Result fields
  always_comb begin
    if (full) begin
      done_res.status     = ST_FULL;
      done_res.slot       = '0;
      done_res.collisions = COLL_W'(coll_inc);
    end else begin
      done_res.slot       = SLOT_W'(pos_r);
      done_res.collisions = COLL_W'(coll_r);
      if (mem_rdata.occ) begin
        done_res.status = ST_FOUND;
      end else if (cmd_r == CMD_INSERT) begin
        done_res.status = ST_INSERTED;
      end else begin
        done_res.status = ST_MISSING;
      end
    end
  end

  // Datapath next values
  always_comb begin
    clr_nxt  = clr_r;
    cnt_nxt  = cnt_r;
    cmd_nxt  = cmd_r;
    key_nxt  = key_r;
    size_nxt = size_r;
    home_nxt = home_r;
    pos_nxt  = pos_r;
    sq_nxt   = sq_r;
    d_nxt    = d_r;
    coll_nxt = coll_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
      end
      S_IDLE: begin
        // Latch the beat and start the reduction from zero
        if (in_valid) begin
          cmd_nxt  = in_cmd;
          key_nxt  = in_key;
          size_nxt = size_i;
          cnt_nxt  = TOP_KBIT;
          pos_nxt  = '0;
          sq_nxt   = '0;
          d_nxt    = SIZE_W'(1);
          coll_nxt = '0;
        end
      end
      S_DIV: begin
        // One key bit per cycle into the remainder
        pos_nxt  = mu_res;
        home_nxt = mu_res;
        cnt_nxt  = cnt_r - KBIT_W'(1);
      end
      S_CMP: begin
        if (!finish) begin
          coll_nxt = coll_inc;
        end
      end
      S_SQ: begin
        // Advance j*j by the next odd number
        sq_nxt = mu_res;
        d_nxt  = d_r + SIZE_W'(2);
      end
      S_POS: begin
        pos_nxt = mu_res;
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    size_r <= size_nxt;
    home_r <= home_nxt;
    pos_r  <= pos_nxt;
    sq_r   <= sq_nxt;
    d_r    <= d_nxt;
    coll_r <= coll_nxt;
  end

  // Remainder stays reduced during the key reduction
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (pos_r < size_r))
    else $error("remainder out of range");

  // Every probed slot lies inside the table, before the bound is reached
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ((pos_r < size_r) && (coll_r < size_r)))
    else $error("probe position or count out of range");

  // An occupied entry is only written by an insert ending on an empty slot
  a_occ_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_wdata.occ) |->
      ((state_r == S_CMP) && (cmd_r == CMD_INSERT) && !mem_rdata.occ))
    else $error("unexpected slot write");

  // A full table reports slot zero and a bound of size collisions
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (done_valid && (done_res.status == ST_FULL)) |->
      ((done_res.slot == '0) && (done_res.collisions == COLL_W'(size_r))))
    else $error("full result malformed");

  // Once the sweep ends the sequencer never returns to it
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |=> (state_r != S_CLEAR))
    else $error("clear sweep re-entered");

endmodule

// ----- rtl/core/quadratic_probe_hash_table_top.sv -----
// Open-addressed integer hash table with alternating quadratic probing.
// Use: in_* beats carry a command (find or insert) and a 31-bit key; each beat yields
// exactly one out_* beat with status, slot and collision count. cfg_wr_en/cfg_wr_data
// load table_size (clamped to 2 .. MAX_SLOTS) and may be written only while idle.
// Steps: accept the beat, reduce the key modulo table_size (one key bit per cycle
// through the shared modular adder), then the home probe and each further probe
// (position update, memory read, compare). The shared adder and the single memory
// port serialise this work, and one beat is worked on at a time.
// Reset: rst_n low clears control state and loads table_size 1021; afterwards a
// sweep over all MAX_SLOTS slots marks every slot empty, with in_ready held low.
// Stall: the result sits in an output register; a new beat is accepted while it
// waits, and a later result waits in the sequencer until out_ready frees the
// register. Depends on qpht_pkg, qpht_seq and qpht_mem.
module quadratic_probe_hash_table_top
  import qpht_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration
  input  logic                cfg_wr_en,
  input  logic [TSIZE_W-1:0]  cfg_wr_data,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [KEY_W-1:0]    in_key,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [COLL_W-1:0]   out_collisions
);

  localparam int unsigned SIZE_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_SLOTS);
  localparam int unsigned CMP_W  = (SIZE_W > TSIZE_W) ? SIZE_W : TSIZE_W;

  logic [TSIZE_W-1:0] tsize_r;
  logic [CMP_W-1:0]   tsize_ext;
  logic [SIZE_W-1:0]  size_eff;

  logic               done_valid;
  logic               done_ready;
  result_t            done_res;
  logic               out_valid_r;
  result_t            out_res_r;

  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  entry_t             mem_wdata;
  entry_t             mem_rdata;

  // Table size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= TSIZE_RESET;
    end else if (cfg_wr_en) begin
      tsize_r <= cfg_wr_data;
    end
  end

  // Clamp the size into 2 .. MAX_SLOTS
  assign tsize_ext = CMP_W'(tsize_r);
  always_comb begin
    if (tsize_ext < CMP_W'(2)) begin
      size_eff = SIZE_W'(2);
    end else if (tsize_ext > CMP_W'(MAX_SLOTS)) begin
      size_eff = SIZE_W'(MAX_SLOTS);
    end else begin
      size_eff = SIZE_W'(tsize_ext);
    end
  end

  qpht_seq #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .size_i     (size_eff),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_res   (done_res),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  qpht_mem #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Output register: load a finished result whenever the slot is free or draining
  assign done_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_res_r <= done_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_slot       = out_res_r.slot;
  assign out_collisions = out_res_r.collisions;

  // A held result is not overwritten while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("output result lost under stall");

  // No new beat is taken during the reset clearing sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("input accepted before clear sweep");

  // A result finished while the held one stalls does not displace it from the register
  a_done_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (done_valid && out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result handed off into a full register");

endmodule

// ----- sim/quadratic_probe_hash_table_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for quadratic_probe_hash_table_top: directed and random finds and
// inserts over many table sizes, each result beat checked against an in-bench table model.
// Depends on qpht_pkg and the hash table RTL.
module tb;
  import qpht_pkg::*;

  // Table model: occupancy, stored keys, current size and the queue of awaited results
  class hash_table_scoreboard;
    bit                 occupied [DEF_MAX_SLOTS];
    bit [KEY_W-1:0]     slot_keys [DEF_MAX_SLOTS];
    bit [KEY_W-1:0]     stored_keys [$];
    logic [TSIZE_W-1:0] size_reg;
    result_t            expected_results [$];
    int unsigned        errors;

    function new();
      size_reg = TSIZE_RESET;
      errors   = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    // Clamp the loaded size into 2 .. MAX_SLOTS
    function int unsigned active_size();
      if (size_reg < 2) return 2;
      if (size_reg > DEF_MAX_SLOTS) return DEF_MAX_SLOTS;
      return 32'(size_reg);
    endfunction

    // Run one find or insert on the model and queue the result it must give
    function void note_request(logic cmd, logic [KEY_W-1:0] key);
      int unsigned sz, home, pos, n, j, sq;
      result_t     res;
      sz   = active_size();
      home = key % sz;
      pos  = home;
      n    = 0;
      // Walk +1, -1, +4, -4, ... around home until a hit, an empty slot or a full table
      while (n < sz && occupied[pos] && slot_keys[pos] != key) begin
        n++;
        j   = (n % 2 == 1) ? (n + 1) / 2 : n / 2;
        sq  = (j * j) % sz;
        pos = (n % 2 == 1) ? (home + sq) % sz : (home + sz - sq) % sz;
      end
      if (n >= sz) begin
        res.status = ST_FULL;
        pos        = 0;
      end else if (occupied[pos]) begin
        res.status = ST_FOUND;
      end else if (cmd == CMD_INSERT) begin
        occupied[pos]  = 1'b1;
        slot_keys[pos] = key;
        stored_keys.push_back(key);
        res.status     = ST_INSERTED;
      end else begin
        res.status = ST_MISSING;
      end
      res.slot       = pos[SLOT_W-1:0];
      res.collisions = n[COLL_W-1:0];
      expected_results.push_back(res);
    endfunction

    // Compare one result beat with the oldest awaited result
    function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                               logic [COLL_W-1:0] collisions);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with none awaited: status %0d slot %0d collisions %0d",
               status, slot, collisions);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          errors++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, slot);
          errors++;
        end
        if (collisions !== want.collisions) begin
          $error("collisions: expected %0d, actual %0d", want.collisions, collisions);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                cfg_wr_en      = 1'b0;
  logic [TSIZE_W-1:0]  cfg_wr_data    = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic                in_cmd         = CMD_FIND;
  logic [KEY_W-1:0]    in_key         = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [COLL_W-1:0]   out_collisions;

  hash_table_scoreboard sb;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 77;
  int unsigned hold_reqs     = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  quadratic_probe_hash_table_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_collisions (out_collisions)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: check each beat, stall at random or hold off on request
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_result(out_status, out_slot, out_collisions);
    if (hold_served != hold_reqs) begin
      hold_served = hold_reqs;
      hold_left   = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold until every awaited result has come back
  task automatic wait_drained();
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic cmd, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(cmd, key);
  endtask

  // Load a table size while idle, then send a burst of random finds and inserts
  task automatic run_phase(input logic [TSIZE_W-1:0] tsize, input int unsigned count,
                           input int unsigned ins_pct, input bit hold_off);
    int unsigned    eff, i;
    logic [31:0]    raw;
    logic [KEY_W-1:0] key;
    logic           cmd;
    wait_drained();
    while (in_ready !== 1'b1) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tsize;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.size_reg = tsize;
    eff = sb.active_size();
    if (hold_off) hold_reqs <= hold_reqs + 1;
    for (i = 0; i < count; i++) begin
      cmd = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_FIND;
      raw = $urandom();
      key = raw[KEY_W-1:0];
      // Mix fresh keys, stored keys, keys sharing a home slot and keys near the top
      case ($urandom_range(9)) inside
        [3:5]: begin
          if (sb.stored_keys.size() != 0)
            key = sb.stored_keys[$urandom_range(sb.stored_keys.size() - 1)];
        end
        [6:8]: key = KEY_W'(eff * $urandom_range(4000) + $urandom_range(3));
        9:     key = KEY_W'({KEY_W{1'b1}} - $urandom_range(3));
        default: ;
      endcase
      send_beat(cmd, key);
      // Pause the sender mid-burst until the block has drained
      if (i == count / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Wait out the clearing sweep
    do @(posedge clk); while (in_ready !== 1'b1);

    // Directed beats at the reset size of 1021: empty table, extremes, home-slot clashes
    send_beat(CMD_FIND,   31'd0);
    send_beat(CMD_INSERT, 31'd0);
    send_beat(CMD_INSERT, 31'd0);
    send_beat(CMD_FIND,   31'd0);
    send_beat(CMD_INSERT, 31'h7FFF_FFFF);
    send_beat(CMD_FIND,   31'h7FFF_FFFF);
    send_beat(CMD_INSERT, 31'd1021);
    send_beat(CMD_INSERT, 31'd2042);
    send_beat(CMD_INSERT, 31'd3063);
    send_beat(CMD_FIND,   31'd3063);
    send_beat(CMD_FIND,   31'd4084);
    send_beat(CMD_INSERT, 31'd1020);
    send_beat(CMD_FIND,   31'd1);
    send_beat(CMD_INSERT, 31'h2AAA_AAAA);
    send_beat(CMD_INSERT, 31'h5555_5555);
    send_beat(CMD_INSERT, 31'h4000_0000);
    send_beat(CMD_FIND,   31'h5555_5555);
    send_beat(CMD_FIND,   31'h7FFF_FFFE);
    in_valid <= 1'b0;

    // Small tables first so they fill up, sizes below 2 clamp to 2
    run_phase(11'd0,   20, 60, 1'b0);
    run_phase(11'd1,   10, 60, 1'b0);
    run_phase(11'd3,   20, 60, 1'b0);
    run_phase(11'd7,   30, 60, 1'b0);
    run_phase(11'd13,  40, 60, 1'b0);
    run_phase(11'd31,  60, 60, 1'b0);
    run_phase(11'd61,  80, 50, 1'b0);
    run_phase(11'd127, 120, 50, 1'b0);

    // Swap the stall pattern: slow sender, mostly ready receiver
    send_idle_pct = 77;
    recv_idle_pct <= 18;
    run_phase(11'd251, 200, 35, 1'b0);
    run_phase(11'd509, 250, 35, 1'b0);

    // No idling; long receiver hold-off; oversize clamps to MAX_SLOTS; back to a small size
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_phase(11'd1021, 300, 30, 1'b0);
    run_phase(11'd1024, 300, 30, 1'b1);
    run_phase(11'd2047, 200, 30, 1'b0);
    run_phase(11'd97,   100, 50, 1'b0);

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("[quadratic_probe_hash_table_top] OK");
    else
      $display("[quadratic_probe_hash_table_top] ERROR");
    $finish;
  end

  // Watchdog: stop with an error if the run hangs
  initial begin
    #30_000_000;
    $display("[quadratic_probe_hash_table_top] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/qpht_pkg.sv
rtl/core/qpht_modunit.sv
rtl/core/qpht_mem.sv
rtl/core/qpht_seq.sv
rtl/core/quadratic_probe_hash_table_top.sv
sim/quadratic_probe_hash_table_tb.sv
